/* hdl/ps2_mouse_cursor_tracker_core_macros.svh */
// Assertion macros shared by the cursor tracker RTL.
`ifndef PS2_MOUSE_CURSOR_TRACKER_CORE_MACROS_SVH
`define PS2_MOUSE_CURSOR_TRACKER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Check prop at each rising edge, skipped while reset is asserted.
`define PMCT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check prop at each rising edge, reset cycles included.
`define PMCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PMCT_ASSERT(lbl, clk, rst_n, prop, msg)
`define PMCT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* hdl/ps2mct_pkg.sv */
// Shared constants for the PS/2 mouse cursor tracker.
`timescale 1ns / 1ps
package ps2mct_pkg;

  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 14;
  localparam int CIDX_W  = 2;
  localparam int BPOS_W  = 2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 14'd1024;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 14'd768;

  // Packet byte positions
  localparam logic [BPOS_W-1:0] BPOS_FIRST = 2'd0;
  localparam logic [BPOS_W-1:0] BPOS_XDELTA = 2'd1;
  localparam logic [BPOS_W-1:0] BPOS_LAST  = 2'd2;

endpackage

/* hdl/ps2mct_coord_update.sv */
// One cursor axis: apply a signed 8-bit delta and clamp to the screen limit.
`timescale 1ns / 1ps
module ps2mct_coord_update #(
  parameter int COORD_BITS = 13
) (
  input  logic [COORD_BITS-1:0]        pos,
  input  logic [ps2mct_pkg::BYTE_W-1:0] delta,
  input  logic                          sub,
  input  logic [ps2mct_pkg::CFG_W-1:0]  limit,
  output logic [COORD_BITS-1:0]        pos_new
);
  import ps2mct_pkg::*;

  localparam int SW = COORD_BITS + 2;
  localparam int LW = (COORD_BITS + 1 > CFG_W) ? COORD_BITS + 1 : CFG_W;
  localparam logic [LW-1:0] CAP = LW'(1) << COORD_BITS;

  logic [LW-1:0]         lim_ext;
  logic [LW-1:0]         lim_m1;
  logic [COORD_BITS-1:0] lim_max;
  logic signed [SW-1:0]  pos_s;
  logic signed [SW-1:0]  dlt_s;
  logic signed [SW-1:0]  sum_s;
  logic signed [SW-1:0]  max_s;

  // Zero limit acts as one, oversized limit saturates at the coordinate range
  assign lim_ext = LW'(limit);
  assign lim_m1  = lim_ext - LW'(1);

  always_comb begin
    if (limit == '0) begin
      lim_max = '0;
    end else if (lim_ext > CAP) begin
      lim_max = '1;
    end else begin
      lim_max = lim_m1[COORD_BITS-1:0];
    end
  end

  assign pos_s = signed'({2'b00, pos});
  assign dlt_s = SW'(signed'(delta));
  assign sum_s = sub ? (pos_s - dlt_s) : (pos_s + dlt_s);
  assign max_s = signed'({2'b00, lim_max});

  always_comb begin
    if (sum_s < 0) begin
      pos_new = '0;
    end else if (sum_s > max_s) begin
      pos_new = lim_max;
    end else begin
      pos_new = sum_s[COORD_BITS-1:0];
    end
  end

endmodule

/* hdl/ps2_mouse_cursor_tracker_core.sv */
// Top level of the PS/2 mouse cursor tracker.
`timescale 1ns / 1ps
// PS/2 mouse cursor tracker.
// Input channel (in_*): one controller byte per word in in_tdata, with the
// auxiliary-data flag in in_tuser. Words with the flag clear are dropped.
// Flagged bytes form three-byte mouse packets; byte 1 is the signed X delta,
// byte 2 the signed Y delta (screen Y grows downward, so it is subtracted).
// Result channel (out_*): after the third byte of each packet one word
// carries the new cursor_x (low bits) and cursor_y, each clamped to
// 0 .. limit-1 (at most 2**COORD_BITS-1); a zero limit holds the axis at 0.
// Configuration (cfg_*): index 0 = screen width, 1 = screen height; other
// indexes are ignored. Write only while the block is idle; cfg_ready is
// always high.
// Timing: a word is taken into an input register, then processed in one
// pass into the output register, which raises out_tvalid with the result.
// One word per cycle is sustained unless a stall holds a packet-ending byte;
// the rate is set by the single input register stage feeding the output register.
// Stall: while out_tready is low and a result waits, a packet-ending byte
// holds in the input register and in_tready drops; other bytes still flow.
// Reset (rst_n low, synchronous): cursor at (0,0), packet position at the
// first byte, limits 1024 x 768, both registers empty.
module ps2_mouse_cursor_tracker_core #(
  parameter int COORD_BITS = 13
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input words
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ps2mct_pkg::BYTE_W-1:0]   in_tdata,   // [7:0] data_byte
  input  logic [0:0]                      in_tuser,   // [0] aux_flag
  // Result words
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [((2*COORD_BITS+7)/8)*8-1:0] out_tdata, // cursor_x, cursor_y, zero pad
  // Configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ps2mct_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [ps2mct_pkg::CFG_W-1:0]    cfg_data
);
  import ps2mct_pkg::*;

  `include "ps2_mouse_cursor_tracker_core_macros.svh"

  localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8;

  // Configuration registers
  logic [CFG_W-1:0] width_r, width_nxt;
  logic [CFG_W-1:0] height_r, height_nxt;

  // Input register stage
  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_flag_r;

  // Packet and cursor state
  logic [BPOS_W-1:0]     bpos_r, bpos_nxt;
  logic [BYTE_W-1:0]     xdelta_r, xdelta_nxt;
  logic [COORD_BITS-1:0] pos_x_r, pos_x_nxt;
  logic [COORD_BITS-1:0] pos_y_r, pos_y_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0] out_x_r, out_y_r;

  logic in_fire;
  logic s1_last;
  logic s1_adv;
  logic s1_fire;
  logic s1_emit;
  logic [COORD_BITS-1:0] new_x, new_y;

  assign cfg_ready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  width_nxt  = cfg_data;
        REG_SCREEN_HEIGHT: height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // The word in the input register ends a packet when flagged at the last slot
  assign s1_last = s1_flag_r && (bpos_r == BPOS_LAST);
  // Only a packet-ending word needs room in the output register
  assign s1_adv  = !s1_last || !out_valid_r || out_tready;
  assign s1_fire = s1_valid_r && s1_adv;
  assign s1_emit = s1_fire && s1_last;

  assign in_tready    = !s1_valid_r || s1_adv;
  assign in_fire      = in_tvalid && in_tready;
  assign s1_valid_nxt = in_fire || (s1_valid_r && !s1_adv);

  ps2mct_coord_update #(.COORD_BITS(COORD_BITS)) u_upd_x (
    .pos     (pos_x_r),
    .delta   (xdelta_r),
    .sub     (1'b0),
    .limit   (width_r),
    .pos_new (new_x)
  );

  ps2mct_coord_update #(.COORD_BITS(COORD_BITS)) u_upd_y (
    .pos     (pos_y_r),
    .delta   (s1_byte_r),
    .sub     (1'b1),
    .limit   (height_r),
    .pos_new (new_y)
  );

  always_comb begin
    bpos_nxt   = bpos_r;
    xdelta_nxt = xdelta_r;
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    if (s1_fire && s1_flag_r) begin
      case (bpos_r)
        BPOS_FIRST: begin
          bpos_nxt = BPOS_XDELTA;
        end
        BPOS_XDELTA: begin
          xdelta_nxt = s1_byte_r;
          bpos_nxt   = BPOS_LAST;
        end
        default: begin
          bpos_nxt  = BPOS_FIRST;
          pos_x_nxt = new_x;
          pos_y_nxt = new_y;
        end
      endcase
    end
  end

  // Hold a waiting result until taken, load a new one behind it
  assign out_valid_nxt = s1_emit || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_RESET;
      height_r    <= HEIGHT_RESET;
      s1_valid_r  <= 1'b0;
      bpos_r      <= BPOS_FIRST;
      xdelta_r    <= '0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      s1_valid_r  <= s1_valid_nxt;
      bpos_r      <= bpos_nxt;
      xdelta_r    <= xdelta_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
      s1_flag_r <= in_tuser[0];
    end
    if (s1_emit) begin
      out_x_r <= new_x;
      out_y_r <= new_y;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_y_r, out_x_r});

  `PMCT_ASSERT(a_emit_loads_out, clk, rst_n, s1_emit |=> out_valid_r, "packet end lost its result")
  `PMCT_ASSERT(a_noflag_holds, clk, rst_n, (!s1_fire || !s1_flag_r) |=> ($stable(bpos_r) && $stable(pos_x_r) && $stable(pos_y_r)), "state moved without a flagged byte")
  `PMCT_ASSERT(a_bpos_range, clk, rst_n, bpos_r != 2'd3, "packet position out of range")
  `PMCT_ASSERT(a_out_only_after_emit, clk, rst_n, (out_valid_r && !$past(out_valid_r)) |-> $past(s1_emit), "result appeared without a packet end")
  `PMCT_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule
